// File: src/mmnh_pkg.sv
`timescale 1ns / 1ps
// Package for the min-max normalized histogram block.
// Holds sizes, widths, command codes and the divider request/response types; no dependencies.
package mmnh_pkg;
  localparam int unsigned MaxSamples = 262144;
  localparam int unsigned AddrW      = 18;
  localparam int unsigned TotW       = 19;
  localparam int unsigned MaxBins    = 256;
  localparam int unsigned BinW       = 8;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned CountW     = 19;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned NumW       = SampleW + BinW;
  localparam int unsigned DivCntW    = $clog2(NumW + 1);

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic                start;
    logic [NumW-1:0]     num;
    logic [SampleW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NumW-1:0]     quot;
  } div_rsp_t;
endpackage

// File: src/min_max_normalized_histogram.sv
`timescale 1ns / 1ps
// Min-max normalized histogram. A load request is accepted while idle; the
// load marked last starts binning unless the image is empty or uniform, and
// each stored sample gets a sample read, a multiply, the 24-step shared
// divider with its start and wait states, and a count read and write. A bin
// read returns its result through the same divider; a read with no
// histogram or an index out of range answers the cycle after acceptance.
// Bin counts carry valid bits, so no clearing pass runs. Depends on
// mmnh_pkg, mmnh_ram and mmnh_div.
module min_max_normalized_histogram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [mmnh_pkg::SampleW-1:0] sample_i,
  input  logic                         last_i,
  input  logic [mmnh_pkg::BinW-1:0]    bin_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mmnh_pkg::SampleW-1:0] bin_value_o,
  output logic [mmnh_pkg::CountW-1:0]  bin_count_o,
  output logic                         ready_res_o,
  output logic                         uniform_o,
  output logic                         overflowed_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mmnh_pkg::CfgW-1:0]    cfg_data_i
);
  import mmnh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_BRD, S_BMUL, S_BDIV, S_BWAIT, S_CRD, S_CWR, S_RWAIT
  } state_e;

  state_e             state_q;
  logic [CfgW-1:0]    cfg_q;
  logic [TotW-1:0]    total_q, k_q;
  logic [SampleW-1:0] min_q, max_q;
  logic               ready_q, uniform_q, ovf_q, closed_q;
  logic [MaxBins-1:0] vld_q;
  logic [NumW-1:0]    prod_q;
  logic [BinW-1:0]    bin_q;
  logic               out_valid_q;
  logic [SampleW-1:0] value_q;
  logic [CountW-1:0]  count_q;
  logic               ready_o_q, uniform_o_q, ovf_o_q;

  logic [CfgW-1:0]    beff;
  logic [BinW-1:0]    bm1;
  logic [SampleW-1:0] range;
  logic               acc, acc_load, acc_read, read_go;
  logic [TotW-1:0]    base_total, new_total;
  logic [SampleW-1:0] base_min, base_max, new_min, new_max;
  logic               room;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [SampleW-1:0] s_rdata;
  logic [CountW-1:0]  c_rdata;
  logic               c_re, c_we;
  logic [BinW-1:0]    c_raddr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign acc         = in_valid_i && in_ready_o;
  assign acc_load    = acc && (command_i == CmdLoad);
  assign acc_read    = acc && (command_i != CmdLoad);

  always_comb begin
    if (cfg_q < CfgW'(2)) begin
      beff = CfgW'(2);
    end else if (cfg_q > CfgW'(MaxBins)) begin
      beff = CfgW'(MaxBins);
    end else begin
      beff = cfg_q;
    end
  end
  assign bm1     = BinW'(beff - 1'b1);
  assign range   = max_q - min_q;
  assign read_go = acc_read && ready_q && ({1'b0, bin_index_i} < beff);

  assign base_total = closed_q ? '0 : total_q;
  assign base_min   = closed_q ? '1 : min_q;
  assign base_max   = closed_q ? '0 : max_q;
  assign room       = base_total < TotW'(MaxSamples);
  assign new_total  = room ? base_total + 1'b1 : base_total;
  assign new_min    = (room && sample_i < base_min) ? sample_i : base_min;
  assign new_max    = (room && sample_i > base_max) ? sample_i : base_max;

  always_comb begin
    div_req.start = (state_q == S_BDIV) || read_go;
    div_req.num   = (state_q == S_BDIV) ? prod_q
                                        : NumW'(bin_index_i) * NumW'(range);
    div_req.den   = (state_q == S_BDIV) ? range : SampleW'(bm1);
  end

  assign c_re    = (state_q == S_CRD) || read_go;
  assign c_raddr = (state_q == S_CRD) ? bin_q : bin_index_i;
  assign c_we    = (state_q == S_CWR);

  mmnh_ram #(.Width(SampleW), .Depth(MaxSamples)) u_store (
    .clk_i   (clk_i),
    .we_i    (acc_load && room),
    .waddr_i (base_total[AddrW-1:0]),
    .wdata_i (sample_i),
    .re_i    (state_q == S_BRD),
    .raddr_i (k_q[AddrW-1:0]),
    .rdata_o (s_rdata)
  );

  mmnh_ram #(.Width(CountW), .Depth(MaxBins)) u_counts (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (bin_q),
    .wdata_i (vld_q[bin_q] ? c_rdata + 1'b1 : CountW'(1)),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  mmnh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CfgW'(MaxBins);
      total_q     <= '0;
      k_q         <= '0;
      min_q       <= '1;
      max_q       <= '0;
      ready_q     <= 1'b0;
      uniform_q   <= 1'b0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc_load) begin
            total_q  <= new_total;
            min_q    <= new_min;
            max_q    <= new_max;
            closed_q <= last_i;
            if (closed_q) begin
              vld_q   <= '0;
              ready_q <= 1'b0;
            end
            ovf_q     <= (closed_q ? 1'b0 : ovf_q) | !room;
            uniform_q <= (closed_q ? 1'b0 : uniform_q)
                         | (last_i && new_total != '0 && new_max <= new_min);
            if (last_i && new_total != '0 && new_max > new_min) begin
              k_q     <= '0;
              state_q <= S_BRD;
            end
          end else if (acc_read) begin
            ready_o_q   <= ready_q;
            uniform_o_q <= uniform_q;
            ovf_o_q     <= ovf_q;
            bin_q       <= bin_index_i;
            if (read_go) begin
              state_q <= S_RWAIT;
            end else begin
              value_q     <= '0;
              count_q     <= '0;
              out_valid_q <= 1'b1;
            end
          end
        end
        S_BRD: state_q <= S_BMUL;
        S_BMUL: begin
          prod_q  <= NumW'(s_rdata - min_q) * NumW'(bm1);
          state_q <= S_BDIV;
        end
        S_BDIV: state_q <= S_BWAIT;
        S_BWAIT: begin
          if (div_rsp.done) begin
            bin_q   <= (div_rsp.quot > NumW'(bm1)) ? bm1 : div_rsp.quot[BinW-1:0];
            state_q <= S_CRD;
          end
        end
        S_CRD: state_q <= S_CWR;
        S_CWR: begin
          vld_q[bin_q] <= 1'b1;
          k_q          <= k_q + 1'b1;
          if (k_q + 1'b1 == total_q) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_BRD;
          end
        end
        S_RWAIT: begin
          if (div_rsp.done) begin
            value_q     <= min_q + div_rsp.quot[SampleW-1:0];
            count_q     <= vld_q[bin_q] ? c_rdata : '0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_value_o  = value_q;
  assign bin_count_o  = count_q;
  assign ready_res_o  = ready_o_q;
  assign uniform_o    = uniform_o_q;
  assign overflowed_o = ovf_o_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_q && uniform_q))
    else $error("ready and uniform flags both set");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotW'(MaxSamples))
    else $error("sample total beyond capacity");

  a_bin_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CWR) |-> (k_q < total_q && vld_q == $past(vld_q)))
    else $error("binning walks past stored samples");
endmodule

// File: src/mmnh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmnh_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: src/mmnh_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on mmnh_pkg.
module mmnh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmnh_pkg::div_req_t req_i,
  output mmnh_pkg::div_rsp_t rsp_o
);
  import mmnh_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [SampleW-1:0] rem_q;
  logic [SampleW-1:0] den_q;
  logic [NumW-1:0]    num_q;
  logic [SampleW:0]   trial;
  logic               ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(NumW);
        rem_q  <= '0;
        num_q  <= req_i.num;
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= ge ? SampleW'(trial - {1'b0, den_q}) : trial[SampleW-1:0];
        num_q <= {num_q[NumW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
endmodule

// File: dv/tb_min_max_normalized_histogram.sv
`timescale 1ns / 1ps
// Testbench for min_max_normalized_histogram: directed table, random images, reads, overflow.
// Results are checked against an in-bench histogram predictor. Depends on mmnh_pkg and the RTL.
module tb_min_max_normalized_histogram;
  import mmnh_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned NumDir     = 30;
  localparam int unsigned RandItems  = 1500;

  typedef enum logic [1:0] {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic      cmd;
    logic [SampleW-1:0] sample;
    logic      last;
    logic [BinW-1:0] idx;
    bit        typed;
    logic [SampleW-1:0] e_val;
    logic [CountW-1:0]  e_cnt;
    bit        e_rdy, e_uni, e_ovf;
  } dir_row_t;

  typedef struct {
    logic [SampleW-1:0] val;
    logic [CountW-1:0]  cnt;
    bit rdy, uni, ovf;
  } bin_read_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [SampleW-1:0] sample_i = '0;
  logic last_i = 1'b0;
  logic [BinW-1:0] bin_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SampleW-1:0] bin_value_o;
  logic [CountW-1:0] bin_count_o;
  logic ready_res_o, uniform_o, overflowed_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;

  min_max_normalized_histogram DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .sample_i, .last_i,
    .bin_index_i, .out_valid_o, .out_ready_i, .bin_value_o, .bin_count_o,
    .ready_res_o, .uniform_o, .overflowed_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // predictor state
  logic [SampleW-1:0] pix_store[$];
  logic [SampleW-1:0] pix_min, pix_max;
  logic [CountW-1:0]  hist[MaxBins];
  bit hist_rdy, hist_uni, hist_ovf, img_closed;
  logic [CfgW-1:0] bins_reg;

  bin_read_t read_expect_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned reads_seen = 0;
  int unsigned images_done = 0;
  int unsigned burst_left = 0;
  bit fast_mode = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;

  dir_row_t dir_tab[NumDir];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL min_max_normalized_histogram");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 30) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic int unsigned eff_bins();
    int unsigned b;
    b = bins_reg;
    if (b < 2) b = 2;
    if (b > MaxBins) b = MaxBins;
    return b;
  endfunction

  function automatic void hist_clear();
    foreach (hist[i]) hist[i] = '0;
    pix_store.delete();
    pix_min = 16'hFFFF;
    pix_max = '0;
    hist_rdy = 0;
    hist_uni = 0;
    hist_ovf = 0;
    img_closed = 0;
  endfunction

  function automatic void hist_load(input logic [SampleW-1:0] v, input logic lst);
    longint unsigned rng, d, bn;
    int unsigned b;
    if (img_closed) hist_clear();
    if (pix_store.size() < MaxSamples) begin
      pix_store.push_back(v);
      if (v < pix_min) pix_min = v;
      if (v > pix_max) pix_max = v;
    end else begin
      hist_ovf = 1;
    end
    if (lst) begin
      img_closed = 1;
      images_done++;
      if (pix_store.size() == 0) return;
      if (pix_max <= pix_min) begin
        hist_uni = 1;
        return;
      end
      b = eff_bins();
      rng = pix_max - pix_min;
      foreach (pix_store[k]) begin
        d = pix_store[k] - pix_min;
        bn = (d * (b - 1)) / rng;
        if (bn > b - 1) bn = b - 1;
        hist[bn] = hist[bn] + 1'b1;
      end
      hist_rdy = 1;
    end
  endfunction

  function automatic bin_read_t hist_read(input logic [BinW-1:0] idx);
    bin_read_t r;
    longint unsigned rng, v;
    int unsigned b;
    b = eff_bins();
    r.val = '0;
    r.cnt = '0;
    if (hist_rdy && idx < b) begin
      rng = pix_max - pix_min;
      v = pix_min + (longint'(idx) * rng) / (b - 1);
      if (v > 65535) v = 65535;
      r.val = v[SampleW-1:0];
      r.cnt = hist[idx];
    end
    r.rdy = hist_rdy;
    r.uni = hist_uni;
    r.ovf = hist_ovf;
    return r;
  endfunction

  // one request; returns after acceptance with in_valid still high
  task automatic send_req(input logic cmd, input logic [SampleW-1:0] s, input logic lst,
                          input logic [BinW-1:0] idx, input bit typed, input bin_read_t ex);
    int unsigned gap;
    if (!fast_mode) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    sample_i <= s;
    last_i <= lst;
    bin_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (cmd == CmdLoad) begin
      hist_load(s, lst);
    end else begin
      read_expect_q.push_back(typed ? ex : hist_read(idx));
    end
  endtask

  // drop valid, drain results, then hold until binning is over
  task automatic wait_idle();
    int unsigned n;
    in_valid_i <= 1'b0;
    n = 0;
    while (read_expect_q.size() != 0 && n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (2) @(posedge clk_i);
    while (!in_ready_o && n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic write_bins(input logic [CfgW-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    bins_reg = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic rand_image(input int unsigned n);
    logic [SampleW-1:0] base, s;
    int unsigned spread, style;
    style = $urandom_range(0, 9);
    base = 16'($urandom);
    spread = (style < 4) ? 65535 : (style < 8) ? $urandom_range(1, 300) : 0;
    for (int unsigned k = 0; k < n; k++) begin
      s = (spread == 65535) ? 16'($urandom) : 16'(base + $urandom_range(0, spread));
      send_req(CmdLoad, s, k == n - 1, 8'($urandom), 0, '{default: 0});
    end
  endtask

  task automatic rand_reads(input int unsigned n);
    logic [BinW-1:0] idx;
    for (int unsigned k = 0; k < n; k++) begin
      idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, eff_bins() - 1));
      send_req(CmdRead, 16'($urandom), 1'($urandom), idx, 0, '{default: 0});
    end
  endtask

  // receiver: check accepted results and stall on its own pattern
  initial begin
    bin_read_t ex;
    int unsigned mode_left, mode, hold_left;
    bit nxt;
    mode_left = 0;
    mode = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        reads_seen++;
        if (read_expect_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          ex = read_expect_q.pop_front();
          if (bin_value_o !== ex.val)
            report($sformatf("bin_value %0d, want %0d", bin_value_o, ex.val));
          if (bin_count_o !== ex.cnt)
            report($sformatf("bin_count %0d, want %0d", bin_count_o, ex.cnt));
          if (ready_res_o !== ex.rdy)
            report($sformatf("ready_res %b, want %b", ready_res_o, ex.rdy));
          if (uniform_o !== ex.uni)
            report($sformatf("uniform %b, want %b", uniform_o, ex.uni));
          if (overflowed_o !== ex.ovf)
            report($sformatf("overflowed %b, want %b", overflowed_o, ex.ovf));
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: nxt = 1'b1;
        1: nxt = $urandom_range(0, 1);
        2: nxt = ($urandom_range(0, 3) == 0);
        default: nxt = ((cycles % 7) < 3);
      endcase
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end
      out_ready_i <= nxt;
    end
  end

  initial begin
    bin_read_t ex;
    dir_tab = '{
      '{RowItem, CmdRead, 0, 0, 0,   1, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 255, 1, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 0, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 65535, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 100, 1, 0, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 0,   1, 0, 2, 1, 0, 0},
      '{RowItem, CmdRead, 0, 0, 255, 1, 65535, 1, 1, 0, 0},
      '{RowItem, CmdRead, 0, 0, 100, 0, 0, 0, 0, 0, 0},
      '{RowCfg,  CmdLoad, 2, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 1,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 2,   1, 0, 0, 1, 0, 0},
      '{RowItem, CmdLoad, 65535, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 65535, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 65534, 1, 0, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 1,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 7, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 7, 1, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 0,   1, 0, 0, 0, 1, 0},
      '{RowCfg,  CmdLoad, 0, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 3, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 9, 1, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 1,   0, 0, 0, 0, 0, 0},
      '{RowCfg,  CmdLoad, 511, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 255, 0, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 5, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 0, 0,   1, 0, 0, 0, 0, 0},
      '{RowItem, CmdLoad, 5, 1, 0,   0, 0, 0, 0, 0, 0},
      '{RowCfg,  CmdLoad, 1, 0, 0,   0, 0, 0, 0, 0, 0},
      '{RowItem, CmdRead, 0, 1, 0,   1, 0, 0, 0, 1, 0}
    };
    hist_clear();
    bins_reg = 9'd256;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) begin
        write_bins(dir_tab[i].sample[CfgW-1:0]);
      end else begin
        ex = '{dir_tab[i].e_val, dir_tab[i].e_cnt, dir_tab[i].e_rdy, dir_tab[i].e_uni,
               dir_tab[i].e_ovf};
        send_req(dir_tab[i].cmd, dir_tab[i].sample, dir_tab[i].last, dir_tab[i].idx,
                 dir_tab[i].typed, ex);
      end
    end

    // hold the receiver off while reads pile up
    write_bins(9'd256);
    rand_image(6);
    hold_asked++;
    for (int k = 0; k < 40; k++) send_req(CmdRead, '0, 1'b0, 8'(k), 0, '{default: 0});
    wait_idle();

    while (items_sent < RandItems) begin
      case ($urandom_range(0, 7))
        0: write_bins(9'd2);
        1: write_bins(9'd256);
        2: write_bins(9'($urandom_range(0, 1)));
        3: write_bins(9'($urandom_range(257, 511)));
        default: write_bins(9'($urandom_range(2, 256)));
      endcase
      rand_reads($urandom_range(0, 3));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) begin
          // short image, then a read before the next image
          rand_image($urandom_range(1, 3));
          rand_reads(1);
        end
        rand_image(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10));
        rand_reads($urandom_range(1, 8));
      end
    end

    // fill the store past capacity with one value
    write_bins(9'($urandom_range(2, 256)));
    fast_mode = 1;
    for (int unsigned k = 0; k <= MaxSamples; k++)
      send_req(CmdLoad, 16'd4321, k == MaxSamples, '0, 0, '{default: 0});
    fast_mode = 0;
    rand_reads(3);

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (read_expect_q.size() != 0) report("reads left without a result");
    $display("covered %0d requests, %0d images, %0d bin reads checked, %0d mismatches",
             items_sent, images_done, reads_seen, errors);
    if (errors == 0) begin
      $display("PASS min_max_normalized_histogram");
    end else begin
      $display("FAIL min_max_normalized_histogram");
    end
    $finish;
  end
endmodule

// File: sim.f
src/mmnh_pkg.sv
src/mmnh_ram.sv
src/mmnh_div.sv
src/min_max_normalized_histogram.sv
dv/tb_min_max_normalized_histogram.sv
